// ===== rtl/mtsr_pkg.sv =====
// mtsr_pkg: types and constants shared by the serial terminal register bank
// used by mtsr_ctrl, mtsr_datapath and multi_terminal_serial_registers_core
`default_nettype none

package mtsr_pkg;

    localparam int MAX_TERMS  = 8;
    localparam int CHAR_W     = 8;
    localparam int DELAY_W    = 16;
    localparam int TERM_IDX_W = 3;
    localparam int TIU_W      = 4;
    localparam int CFG_DATA_W = 16;

    localparam logic [TIU_W-1:0]   TIU_RESET   = 4'd2;
    localparam logic [DELAY_W-1:0] DELAY_RESET = 16'd1;

    typedef enum logic [1:0] {
        KIND_READ  = 2'd0,
        KIND_WRITE = 2'd1,
        KIND_CHAR  = 2'd2,
        KIND_TICK  = 2'd3
    } kind_t;

    typedef enum logic [3:0] {
        REG_RX_CTRL = 4'd0,
        REG_RX_DATA = 4'd4,
        REG_TX_CTRL = 4'd8,
        REG_TX_DATA = 4'd12
    } reg_off_t;

    typedef enum logic {
        CFG_TERMS_IN_USE = 1'b0,
        CFG_TX_DELAY     = 1'b1
    } cfg_idx_t;

    typedef struct packed {
        logic load;
        logic advance;
    } dp_cmd_t;

    typedef struct packed {
        logic last;
    } dp_status_t;

endpackage

`default_nettype wire

// ===== rtl/mtsr_ctrl.sv =====
// mtsr_ctrl: controller state machine sequencing accept and result words
// depends on mtsr_pkg
`default_nettype none

module mtsr_ctrl
(
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 start,
    input  wire mtsr_pkg::dp_status_t status,
    output logic                      busy,
    output logic                      strobe,
    output mtsr_pkg::dp_cmd_t         cmd
);

    typedef enum logic {
        ST_IDLE,
        ST_EMIT
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic   accept;

    // final result word of an item overlaps acceptance of the next one
    assign busy   = (state_reg == ST_EMIT) && !status.last;
    assign accept = start && !busy;
    assign strobe = (state_reg == ST_EMIT);

    assign cmd.load    = accept;
    assign cmd.advance = (state_reg == ST_EMIT);

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    state_next = ST_EMIT;
                end
            end
            ST_EMIT:
            begin
                if (accept)
                begin
                    state_next = ST_EMIT;
                end
                else if (status.last)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

`default_nettype wire

// ===== rtl/mtsr_datapath.sv =====
// mtsr_datapath: per-terminal registers, transmit countdowns, config and result select
// depends on mtsr_pkg
`default_nettype none

module mtsr_datapath
#(
    parameter int NUM_TERMS = 2
)
(
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    input  wire mtsr_pkg::dp_cmd_t               cmd,
    output mtsr_pkg::dp_status_t                 status,
    input  wire logic                            cfg_write,
    input  wire logic                            cfg_index,
    input  wire logic [mtsr_pkg::CFG_DATA_W-1:0] cfg_data,
    input  wire logic [1:0]                      kind,
    input  wire logic [7:0]                      address,
    input  wire logic [31:0]                     write_value,
    input  wire logic [2:0]                      source_terminal,
    input  wire logic [7:0]                      received_char,
    output logic [7:0]                           read_value,
    output logic                                 bus_error,
    output logic                                 send_valid,
    output logic [2:0]                           send_terminal,
    output logic [7:0]                           send_char,
    output logic [7:0]                           receive_irq_lines,
    output logic [7:0]                           transmit_irq_lines
);

    localparam int CW = mtsr_pkg::CHAR_W;
    localparam int DW = mtsr_pkg::DELAY_W;
    localparam int TW = mtsr_pkg::TIU_W;

    logic [TW-1:0]        tiu_reg;
    logic [DW-1:0]        delay_reg;

    logic [NUM_TERMS-1:0] rx_ready_reg, rx_ready_next;
    logic [NUM_TERMS-1:0] rx_en_reg, rx_en_next;
    logic [NUM_TERMS-1:0] tx_ready_reg, tx_ready_next;
    logic [NUM_TERMS-1:0] tx_en_reg, tx_en_next;
    logic [CW-1:0]        rx_byte_reg [NUM_TERMS];
    logic [CW-1:0]        rx_byte_next [NUM_TERMS];
    logic [CW-1:0]        tx_byte_reg [NUM_TERMS];
    logic [CW-1:0]        tx_byte_next [NUM_TERMS];
    logic [DW-1:0]        cd_reg [NUM_TERMS];
    logic [DW-1:0]        cd_next [NUM_TERMS];

    logic [NUM_TERMS-1:0] pend_reg, pend_next;
    logic [CW-1:0]        rd_reg, rd_next;
    logic                 err_reg, err_next;

    logic [TW-1:0]        dev;
    logic [3:0]           reg_off;
    logic                 dev_ok;
    logic                 src_ok;
    logic                 sel_rx_ready;
    logic                 sel_rx_en;
    logic                 sel_tx_ready;
    logic                 sel_tx_en;
    logic [CW-1:0]        sel_rx_byte;
    logic [DW-1:0]        load_delay;

    logic                 found;
    logic [2:0]           found_term;
    logic [CW-1:0]        found_char;

    assign dev     = address[7:4];
    assign reg_off = address[3:0];
    assign dev_ok  = (dev < tiu_reg) && (dev < TW'(NUM_TERMS));
    assign src_ok  = (TW'(source_terminal) < tiu_reg) && (TW'(source_terminal) < TW'(NUM_TERMS));
    assign load_delay = (delay_reg == '0) ? DW'(1) : delay_reg;

    always_comb
    begin
        sel_rx_ready = 1'b0;
        sel_rx_en    = 1'b0;
        sel_tx_ready = 1'b0;
        sel_tx_en    = 1'b0;
        sel_rx_byte  = '0;
        for (int t = 0; t < NUM_TERMS; t++)
        begin
            if (dev == TW'(t))
            begin
                sel_rx_ready = rx_ready_reg[t];
                sel_rx_en    = rx_en_reg[t];
                sel_tx_ready = tx_ready_reg[t];
                sel_tx_en    = tx_en_reg[t];
                sel_rx_byte  = rx_byte_reg[t];
            end
        end
    end

    always_comb
    begin
        rx_ready_next = rx_ready_reg;
        rx_en_next    = rx_en_reg;
        tx_ready_next = tx_ready_reg;
        tx_en_next    = tx_en_reg;
        rx_byte_next  = rx_byte_reg;
        tx_byte_next  = tx_byte_reg;
        cd_next       = cd_reg;
        pend_next     = pend_reg;
        rd_next       = rd_reg;
        err_next      = err_reg;
        if (cmd.load)
        begin
            rd_next   = '0;
            err_next  = 1'b0;
            pend_next = '0;
            unique case (mtsr_pkg::kind_t'(kind))
                mtsr_pkg::KIND_READ:
                begin
                    err_next = 1'b1;
                    if (dev_ok)
                    begin
                        unique case (reg_off)
                            mtsr_pkg::REG_RX_CTRL:
                            begin
                                rd_next  = {6'd0, sel_rx_en, sel_rx_ready};
                                err_next = 1'b0;
                            end
                            mtsr_pkg::REG_RX_DATA:
                            begin
                                rd_next  = sel_rx_byte;
                                err_next = 1'b0;
                                for (int t = 0; t < NUM_TERMS; t++)
                                begin
                                    if (dev == TW'(t))
                                    begin
                                        rx_ready_next[t] = 1'b0;
                                    end
                                end
                            end
                            mtsr_pkg::REG_TX_CTRL:
                            begin
                                rd_next  = {6'd0, sel_tx_en, sel_tx_ready};
                                err_next = 1'b0;
                            end
                            default:
                            begin
                                err_next = 1'b1;
                            end
                        endcase
                    end
                end
                mtsr_pkg::KIND_WRITE:
                begin
                    err_next = 1'b1;
                    if (dev_ok)
                    begin
                        unique case (reg_off)
                            mtsr_pkg::REG_RX_CTRL:
                            begin
                                err_next = 1'b0;
                                for (int t = 0; t < NUM_TERMS; t++)
                                begin
                                    if (dev == TW'(t))
                                    begin
                                        rx_ready_next[t] = write_value[0];
                                        rx_en_next[t]    = write_value[1];
                                    end
                                end
                            end
                            mtsr_pkg::REG_TX_CTRL:
                            begin
                                err_next = 1'b0;
                                for (int t = 0; t < NUM_TERMS; t++)
                                begin
                                    if (dev == TW'(t))
                                    begin
                                        tx_ready_next[t] = write_value[0];
                                        tx_en_next[t]    = write_value[1];
                                    end
                                end
                            end
                            mtsr_pkg::REG_TX_DATA:
                            begin
                                err_next = 1'b0;
                                for (int t = 0; t < NUM_TERMS; t++)
                                begin
                                    if (dev == TW'(t))
                                    begin
                                        tx_byte_next[t]  = write_value[CW-1:0];
                                        tx_ready_next[t] = 1'b0;
                                        cd_next[t]       = load_delay;
                                    end
                                end
                            end
                            default:
                            begin
                                err_next = 1'b1;
                            end
                        endcase
                    end
                end
                mtsr_pkg::KIND_CHAR:
                begin
                    if (src_ok)
                    begin
                        for (int t = 0; t < NUM_TERMS; t++)
                        begin
                            if (source_terminal == 3'(t))
                            begin
                                rx_byte_next[t]  = received_char;
                                rx_ready_next[t] = 1'b1;
                            end
                        end
                    end
                end
                mtsr_pkg::KIND_TICK:
                begin
                    for (int t = 0; t < NUM_TERMS; t++)
                    begin
                        if (cd_reg[t] != '0)
                        begin
                            cd_next[t] = cd_reg[t] - DW'(1);
                            if (cd_reg[t] == DW'(1))
                            begin
                                tx_ready_next[t] = 1'b1;
                                pend_next[t]     = 1'b1;
                            end
                        end
                    end
                end
                default:
                begin
                    err_next = 1'b0;
                end
            endcase
        end
        else if (cmd.advance)
        begin
            // drop the lowest finished transmitter
            pend_next = pend_reg & (pend_reg - NUM_TERMS'(1));
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tiu_reg      <= mtsr_pkg::TIU_RESET;
            delay_reg    <= mtsr_pkg::DELAY_RESET;
            rx_ready_reg <= '0;
            rx_en_reg    <= '0;
            tx_ready_reg <= '1;
            tx_en_reg    <= '0;
            pend_reg     <= '0;
            rd_reg       <= '0;
            err_reg      <= 1'b0;
            for (int t = 0; t < NUM_TERMS; t++)
            begin
                rx_byte_reg[t] <= '0;
                tx_byte_reg[t] <= '0;
                cd_reg[t]      <= '0;
            end
        end
        else
        begin
            if (cfg_write)
            begin
                unique case (mtsr_pkg::cfg_idx_t'(cfg_index))
                    mtsr_pkg::CFG_TERMS_IN_USE: tiu_reg   <= cfg_data[TW-1:0];
                    mtsr_pkg::CFG_TX_DELAY:     delay_reg <= cfg_data[DW-1:0];
                    default:                    tiu_reg   <= tiu_reg;
                endcase
            end
            rx_ready_reg <= rx_ready_next;
            rx_en_reg    <= rx_en_next;
            tx_ready_reg <= tx_ready_next;
            tx_en_reg    <= tx_en_next;
            pend_reg     <= pend_next;
            rd_reg       <= rd_next;
            err_reg      <= err_next;
            rx_byte_reg  <= rx_byte_next;
            tx_byte_reg  <= tx_byte_next;
            cd_reg       <= cd_next;
        end
    end

    // lowest pending terminal wins
    always_comb
    begin
        found      = 1'b0;
        found_term = '0;
        found_char = '0;
        for (int t = NUM_TERMS - 1; t >= 0; t--)
        begin
            if (pend_reg[t])
            begin
                found      = 1'b1;
                found_term = 3'(t);
                found_char = tx_byte_reg[t];
            end
        end
    end

    assign status.last = ((pend_reg & (pend_reg - NUM_TERMS'(1))) == '0);

    assign read_value         = found ? '0 : rd_reg;
    assign bus_error          = found ? 1'b0 : err_reg;
    assign send_valid         = found;
    assign send_terminal      = found_term;
    assign send_char          = found_char;
    assign receive_irq_lines  = 8'(rx_ready_reg & rx_en_reg);
    assign transmit_irq_lines = 8'(tx_ready_reg & tx_en_reg);

endmodule

`default_nettype wire

// ===== rtl/multi_terminal_serial_registers_core.sv =====
// multi_terminal_serial_registers_core: top level of the serial terminal register bank
// instantiates mtsr_ctrl and mtsr_datapath, depends on mtsr_pkg
//
// usage:
//   a word (bus read, bus write, received character or time tick) is taken on a
//   rising edge with start high and busy low. its results appear on the result
//   ports one per cycle, each marked by strobe for exactly one cycle; last marks
//   the final result of the word. the receiver cannot stall, results are not held.
//   latency: first result in the cycle after the word is taken.
//   throughput: a bus access or character gives one result and the next word can
//   be taken in the cycle that result is shown, so one word per cycle. a tick
//   gives one result per finishing transmitter (at least one) and holds busy high
//   until its last result; the result sequencer walks the finished terminals.
//   configuration: cfg_write, cfg_index 0 (terminals in use) or 1 (transmit delay
//   in ticks); users must write only while no word is in flight; this is not checked.
//   reset: asynchronous, active low; receivers not ready, transmitters ready,
//   no transmission pending, 2 terminals in use, delay of one tick.
`default_nettype none

module multi_terminal_serial_registers_core
#(
    parameter int NUM_TERMS = 2
)
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        start,
    output logic             busy,
    input  wire logic        cfg_write,
    input  wire logic        cfg_index,
    input  wire logic [15:0] cfg_data,
    input  wire logic [1:0]  kind,
    input  wire logic [7:0]  address,
    input  wire logic [31:0] write_value,
    input  wire logic [2:0]  source_terminal,
    input  wire logic [7:0]  received_char,
    output logic             strobe,
    output logic [7:0]       read_value,
    output logic             bus_error,
    output logic             send_valid,
    output logic [2:0]       send_terminal,
    output logic [7:0]       send_char,
    output logic [7:0]       receive_irq_lines,
    output logic [7:0]       transmit_irq_lines,
    output logic             last
);

    mtsr_pkg::dp_cmd_t    cmd;
    mtsr_pkg::dp_status_t status;

    mtsr_ctrl u_ctrl
    (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (start),
        .status (status),
        .busy   (busy),
        .strobe (strobe),
        .cmd    (cmd)
    );

    mtsr_datapath
    #(
        .NUM_TERMS (NUM_TERMS)
    )
    u_datapath
    (
        .clk                (clk),
        .rst_n              (rst_n),
        .cmd                (cmd),
        .status             (status),
        .cfg_write          (cfg_write),
        .cfg_index          (cfg_index),
        .cfg_data           (cfg_data),
        .kind               (kind),
        .address            (address),
        .write_value        (write_value),
        .source_terminal    (source_terminal),
        .received_char      (received_char),
        .read_value         (read_value),
        .bus_error          (bus_error),
        .send_valid         (send_valid),
        .send_terminal      (send_terminal),
        .send_char          (send_char),
        .receive_irq_lines  (receive_irq_lines),
        .transmit_irq_lines (transmit_irq_lines)
    );

    assign last = status.last;

endmodule

`default_nettype wire
